// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands clocked on clk with rst_n as disable.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge out of reset
`define ASSERT_CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be true out of reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/phscr_pkg.sv =====
// ---------------------------------------------------------------------------
// phscr_pkg
// Shared widths, constants and types of the pack header SCR regenerator.
// ---------------------------------------------------------------------------
package phscr_pkg;

  localparam int HIGH_W   = 48;
  localparam int LOW_W    = 32;
  localparam int CLK_W    = 42;
  localparam int BASE_W   = 33;
  localparam int EXT_W    = 9;
  localparam int MUX_W    = 22;
  localparam int STEP_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 22;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_REG_SCR_STEP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REG_DEF_MUX   = 2'd1;

  localparam logic [STEP_W-1:0] SCR_STEP_RST = 16'd43886;
  localparam logic [MUX_W-1:0]  MUX_RATE_RST = 22'd25200;

  localparam logic [CLK_W-1:0]  CLK_PER_BASE = 42'd300;
  localparam logic [7:0]        STUFF_BYTE   = 8'hF8;

  // ceil(2^51 / 300): exact floor division by 300 for any 42-bit value
  localparam int              RECIP_SHIFT = 51;
  localparam logic [42:0]     RECIP       = 43'd7505999378951;
  localparam logic [20:0]     RECIP_HI    = RECIP[42:22];
  localparam logic [21:0]     RECIP_LO    = RECIP[21:0];

  typedef struct packed {
    logic             ok;
    logic [CLK_W-1:0] raw_clk;
    logic [MUX_W-1:0] mux_rate;
  } hdr_item_t;

  typedef struct packed {
    logic             mux_we;
    logic [MUX_W-1:0] mux_rate;
  } cfg_wr_t;

endpackage

// ===== hw/rtl/pack_header_scr_regenerator_unit.sv =====
// ---------------------------------------------------------------------------
// pack_header_scr_regenerator_unit
// Rewrites MPEG-2 program stream pack headers with a regenerated SCR.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one transfer carries the 10 body bytes of a pack header
//           (in_header_high = bytes 0..5, in_header_low = bytes 6..9).
//   out_* : one transfer per header: repacked bytes, header_ok and the
//           27 MHz clock written into the header.
//   cfg_* : register writes, index 0 scr_step, index 1 default_mux_rate;
//           other indexes are dropped. cfg_ready is always high. Write
//           only while no header is in flight.
// From input transfer to out_valid a header passes front decode,
// queue, clock resolution loop and three divide-by-300 stages feeding
// the output register. Throughput is one header per cycle while
// out_ready is high, set by the compare/add loop that updates the next
// clock. A 4-entry queue keeps in_ready high while the receiver holds
// out_ready low, until the queue fills; the back pipeline holds its
// contents. Reset clears the next clock, restores the register
// defaults and the held mux rate, and empties the pipeline.
// ---------------------------------------------------------------------------
module pack_header_scr_regenerator_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [phscr_pkg::HIGH_W-1:0]      in_header_high,
  input  logic [phscr_pkg::LOW_W-1:0]       in_header_low,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [phscr_pkg::HIGH_W-1:0]      out_out_high,
  output logic [phscr_pkg::LOW_W-1:0]       out_out_low,
  output logic                              out_header_ok,
  output logic [phscr_pkg::CLK_W-1:0]       out_clock_used,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [phscr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [phscr_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import phscr_pkg::*;

  logic [STEP_W-1:0] scr_step_r;
  cfg_wr_t           cfg_wr;
  logic              cfg_fire;
  logic              f_valid, f_ready;
  hdr_item_t         f_item;
  logic              q_valid, q_pop;
  hdr_item_t         q_item;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_comb begin
    cfg_wr.mux_we   = 1'b0;
    cfg_wr.mux_rate = cfg_data[MUX_W-1:0];
    unique case (cfg_index)
      CFG_REG_DEF_MUX: cfg_wr.mux_we = cfg_fire;
      default:         cfg_wr.mux_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_step_r <= SCR_STEP_RST;
    end else if (cfg_fire && (cfg_index == CFG_REG_SCR_STEP)) begin
      scr_step_r <= cfg_data[STEP_W-1:0];
    end
  end

  phscr_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_header_high (in_header_high),
    .in_header_low  (in_header_low),
    .item_valid     (f_valid),
    .item_ready     (f_ready),
    .item           (f_item)
  );

  phscr_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_item   (q_item)
  );

  phscr_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .scr_step       (scr_step_r),
    .cfg_wr         (cfg_wr),
    .fifo_valid     (q_valid),
    .fifo_pop       (q_pop),
    .fifo_item      (q_item),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_out_high   (out_out_high),
    .out_out_low    (out_out_low),
    .out_header_ok  (out_header_ok),
    .out_clock_used (out_clock_used)
  );

endmodule

// ===== hw/rtl/phscr_front.sv =====
// ---------------------------------------------------------------------------
// phscr_front
// Input stage: checks marker bits, extracts SCR base, extension and mux
// rate, and forms base*300+ext for the queue.
// ---------------------------------------------------------------------------
module phscr_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [phscr_pkg::HIGH_W-1:0]  in_header_high,
  input  logic [phscr_pkg::LOW_W-1:0]   in_header_low,
  output logic                          item_valid,
  input  logic                          item_ready,
  output phscr_pkg::hdr_item_t          item
);
  import phscr_pkg::*;

  logic [7:0]        b0, b1, b2, b3, b4, b5, b6, b7, b8;
  logic [BASE_W-1:0] base;
  logic [EXT_W-1:0]  ext;
  hdr_item_t         dec;
  logic              front_v_r;
  hdr_item_t         front_r;
  logic              adv;

  assign b0 = in_header_high[47:40];
  assign b1 = in_header_high[39:32];
  assign b2 = in_header_high[31:24];
  assign b3 = in_header_high[23:16];
  assign b4 = in_header_high[15:8];
  assign b5 = in_header_high[7:0];
  assign b6 = in_header_low[31:24];
  assign b7 = in_header_low[23:16];
  assign b8 = in_header_low[15:8];

  assign base = {b0[5:3], b0[1:0], b1, b2[7:3], b2[1:0], b3, b4[7:3]};
  assign ext  = {b4[1:0], b5[7:1]};

  always_comb begin
    dec.ok       = (b8[1:0] == 2'b11) && b5[0] && b4[2] && b2[2] &&
                   ((b0 & 8'hC4) == 8'h44);
    dec.raw_clk  = CLK_W'(base) * CLK_PER_BASE + CLK_W'(ext);
    dec.mux_rate = {b6, b7, b8[7:2]};
  end

  assign adv        = !front_v_r || item_ready;
  assign in_ready   = adv;
  assign item_valid = front_v_r;
  assign item       = front_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_v_r <= 1'b0;
    end else if (adv) begin
      front_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      front_r <= dec;
    end
  end

endmodule

// ===== hw/rtl/phscr_fifo.sv =====
// ---------------------------------------------------------------------------
// phscr_fifo
// Short queue of decoded headers between the front and back stages.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module phscr_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 push_ready,
  input  phscr_pkg::hdr_item_t push_item,
  output logic                 pop_valid,
  input  logic                 pop,
  output phscr_pkg::hdr_item_t pop_item
);
  import phscr_pkg::*;

  hdr_item_t            mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [FIFO_CW-1:0]   count_r;
  logic                 do_push;

  assign push_ready = (count_r != FIFO_CW'(FIFO_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push && push_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({do_push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  `ASSERT_NEVER(a_fifo_over, count_r > FIFO_CW'(FIFO_DEPTH), "queue count beyond depth")
  `ASSERT_NEVER(a_fifo_under, pop && (count_r == '0), "pop from empty queue")

endmodule

// ===== hw/rtl/phscr_back.sv =====
// ---------------------------------------------------------------------------
// phscr_back
// Clock resolution loop, divide-by-300 pipeline and header repacking with
// the output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module phscr_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [phscr_pkg::STEP_W-1:0]  scr_step,
  input  phscr_pkg::cfg_wr_t            cfg_wr,
  input  logic                          fifo_valid,
  output logic                          fifo_pop,
  input  phscr_pkg::hdr_item_t          fifo_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [phscr_pkg::HIGH_W-1:0]  out_out_high,
  output logic [phscr_pkg::LOW_W-1:0]   out_out_low,
  output logic                          out_header_ok,
  output logic [phscr_pkg::CLK_W-1:0]   out_clock_used
);
  import phscr_pkg::*;

  logic              adv, pop;
  logic [CLK_W-1:0]  next_clock_r, next_clock_nxt;
  logic [MUX_W-1:0]  held_mux_r, held_mux_nxt;
  logic              seen_valid_r;
  logic [CLK_W-1:0]  clk_sel;

  // loop stage
  logic              l_v_r, l_ok_r;
  logic [CLK_W-1:0]  l_clk_r;
  logic [MUX_W-1:0]  l_mux_r;
  // partial products
  logic              d1_v_r, d1_ok_r;
  logic [CLK_W-1:0]  d1_clk_r;
  logic [MUX_W-1:0]  d1_mux_r;
  logic [42:0]       pp00_r, pp10_r;
  logic [41:0]       pp01_r, pp11_r;
  // half sums
  logic              d2_v_r, d2_ok_r;
  logic [CLK_W-1:0]  d2_clk_r;
  logic [MUX_W-1:0]  d2_mux_r;
  logic [64:0]       sa_r, sb_r;
  // quotient
  logic              d3_v_r, d3_ok_r;
  logic [CLK_W-1:0]  d3_clk_r;
  logic [MUX_W-1:0]  d3_mux_r;
  logic [BASE_W-1:0] q_r;
  logic [85:0]       prod_sum;
  // output
  logic              out_v_r;
  logic [HIGH_W-1:0] out_high_r;
  logic [LOW_W-1:0]  out_low_r;
  logic              out_ok_r;
  logic [CLK_W-1:0]  out_clk_r;
  logic [17:0]       q300;
  logic [EXT_W-1:0]  rem;
  logic [BASE_W-1:0] th;

  assign adv      = !out_v_r || out_ready;
  assign pop      = fifo_valid && adv;
  assign fifo_pop = pop;

  always_comb begin
    clk_sel        = next_clock_r;
    next_clock_nxt = next_clock_r;
    held_mux_nxt   = held_mux_r;
    if (fifo_item.ok) begin
      clk_sel        = (fifo_item.raw_clk < next_clock_r) ? next_clock_r : fifo_item.raw_clk;
      next_clock_nxt = clk_sel + CLK_W'(scr_step);
      held_mux_nxt   = fifo_item.mux_rate;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_clock_r <= '0;
      held_mux_r   <= MUX_RATE_RST;
      seen_valid_r <= 1'b0;
      l_v_r        <= 1'b0;
      d1_v_r       <= 1'b0;
      d2_v_r       <= 1'b0;
      d3_v_r       <= 1'b0;
      out_v_r      <= 1'b0;
    end else begin
      if (pop) begin
        next_clock_r <= next_clock_nxt;
        held_mux_r   <= held_mux_nxt;
        if (fifo_item.ok) begin
          seen_valid_r <= 1'b1;
        end
      end else if (cfg_wr.mux_we && !seen_valid_r) begin
        held_mux_r <= cfg_wr.mux_rate;
      end
      if (adv) begin
        l_v_r   <= pop;
        d1_v_r  <= l_v_r;
        d2_v_r  <= d1_v_r;
        d3_v_r  <= d2_v_r;
        out_v_r <= d3_v_r;
      end
    end
  end

  assign prod_sum = 86'(sa_r) + (86'(sb_r) << 21);
  assign th       = q_r;
  assign q300     = 18'(q_r[8:0]) * 18'd300;
  assign rem      = d3_clk_r[8:0] - q300[8:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      l_ok_r   <= fifo_item.ok;
      l_clk_r  <= clk_sel;
      l_mux_r  <= held_mux_nxt;

      d1_ok_r  <= l_ok_r;
      d1_clk_r <= l_clk_r;
      d1_mux_r <= l_mux_r;
      pp00_r   <= 43'(l_clk_r[20:0]) * 43'(RECIP_LO);
      pp01_r   <= 42'(l_clk_r[20:0]) * 42'(RECIP_HI);
      pp10_r   <= 43'(l_clk_r[41:21]) * 43'(RECIP_LO);
      pp11_r   <= 42'(l_clk_r[41:21]) * 42'(RECIP_HI);

      d2_ok_r  <= d1_ok_r;
      d2_clk_r <= d1_clk_r;
      d2_mux_r <= d1_mux_r;
      sa_r     <= 65'(pp00_r) + (65'(pp01_r) << 22);
      sb_r     <= 65'(pp10_r) + (65'(pp11_r) << 22);

      d3_ok_r  <= d2_ok_r;
      d3_clk_r <= d2_clk_r;
      d3_mux_r <= d2_mux_r;
      q_r      <= prod_sum[RECIP_SHIFT+BASE_W-1:RECIP_SHIFT];

      out_ok_r   <= d3_ok_r;
      out_clk_r  <= d3_clk_r;
      out_high_r <= {2'b01, th[32:30], 1'b1, th[29:28],
                     th[27:20],
                     th[19:15], 1'b1, th[14:13],
                     th[12:5],
                     th[4:0], 1'b1, rem[8:7],
                     rem[6:0], 1'b1};
      out_low_r  <= {d3_mux_r[21:14], d3_mux_r[13:6], d3_mux_r[5:0], 2'b11, STUFF_BYTE};
    end
  end

  assign out_valid      = out_v_r;
  assign out_out_high   = out_high_r;
  assign out_out_low    = out_low_r;
  assign out_header_ok  = out_ok_r;
  assign out_clock_used = out_clk_r;

  `ASSERT_CHK(a_next_hold, !pop |=> $stable(next_clock_r), "next clock moved without a transfer")
  `ASSERT_CHK(a_bad_uses_next, (pop && !fifo_item.ok) |=> (l_clk_r == $past(next_clock_r)), "invalid header did not take next clock")
  `ASSERT_CHK(a_pop_fills, pop |=> l_v_r, "popped header lost at loop stage")

endmodule
